// File: design/sc1cp_pkg.sv
package sc1cp_pkg;

  localparam int CP_W      = 21;
  localparam int ASCII_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int TABLE_LEN = 58;

  typedef logic [CP_W-1:0]      codepoint_t;
  typedef logic [ASCII_W-1:0]   ascii_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scan_byte;
  } in_word_t;

  typedef struct packed {
    logic       pop_valid;
    codepoint_t codepoint;
    ascii_t     ascii_char;
    logic       not_empty;
    logic       dropped_oldest;
  } out_word_t;

  typedef struct packed {
    codepoint_t up;
    codepoint_t down;
    codepoint_t left;
    codepoint_t right;
    codepoint_t home;
    codepoint_t fkey_one;
    codepoint_t spotlight;
  } cfg_codes_t;

  typedef struct packed {
    logic shift;
    logic altgr;
    logic prefix;
    logic gui;
    logic ctrl;
  } kbd_flags_t;

  typedef struct packed {
    logic       push;
    codepoint_t cp;
  } push_req_t;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam cfg_idx_t CFG_UP        = 3'd0;
  localparam cfg_idx_t CFG_DOWN      = 3'd1;
  localparam cfg_idx_t CFG_LEFT      = 3'd2;
  localparam cfg_idx_t CFG_RIGHT     = 3'd3;
  localparam cfg_idx_t CFG_HOME      = 3'd4;
  localparam cfg_idx_t CFG_FKEY_ONE  = 3'd5;
  localparam cfg_idx_t CFG_SPOTLIGHT = 3'd6;

  localparam codepoint_t RST_UP        = 21'h00E000;
  localparam codepoint_t RST_DOWN      = 21'h00E001;
  localparam codepoint_t RST_LEFT      = 21'h00E002;
  localparam codepoint_t RST_RIGHT     = 21'h00E003;
  localparam codepoint_t RST_HOME      = 21'h00E004;
  localparam codepoint_t RST_FKEY_ONE  = 21'h00E005;
  localparam codepoint_t RST_SPOTLIGHT = 21'h00E006;

  localparam logic [7:0] SC_PREFIX      = 8'hE0;
  localparam logic [7:0] SC_LSHIFT      = 8'h2A;
  localparam logic [7:0] SC_RSHIFT      = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_ALT         = 8'h38;
  localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
  localparam logic [7:0] SC_LGUI        = 8'h5B;
  localparam logic [7:0] SC_RGUI        = 8'h5C;
  localparam logic [7:0] SC_LGUI_BRK    = 8'hDB;
  localparam logic [7:0] SC_RGUI_BRK    = 8'hDC;
  localparam logic [7:0] SC_LCTRL      = 8'h1D;
  localparam logic [7:0] SC_LCTRL_BRK  = 8'h9D;
  localparam logic [7:0] SC_UP          = 8'h48;
  localparam logic [7:0] SC_DOWN        = 8'h50;
  localparam logic [7:0] SC_LEFT        = 8'h4B;
  localparam logic [7:0] SC_RIGHT       = 8'h4D;
  localparam logic [7:0] SC_HOME        = 8'h47;
  localparam logic [7:0] SC_F1          = 8'h3B;
  localparam logic [7:0] SC_ENTER       = 8'h1C;
  localparam logic [7:0] SC_BKSP        = 8'h0E;
  localparam logic [7:0] SC_DEL         = 8'h53;

  localparam ascii_t CH_NUL       = 7'h00;
  localparam ascii_t CH_BS        = 7'h08;
  localparam ascii_t CH_LF        = 7'h0A;
  localparam ascii_t CH_SPACE     = 7'h20;
  localparam ascii_t CH_UNKNOWN   = 7'h3F;
  localparam codepoint_t ASCII_MAX = 21'h00007F;

  localparam ascii_t PLAIN_MAP [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam ascii_t SHIFT_MAP [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  function automatic ascii_t key_char(input logic [7:0] sc, input logic shifted);
    ascii_t ch;
    ch = CH_NUL;
    if (sc < 8'(TABLE_LEN)) begin
      ch = shifted ? SHIFT_MAP[sc[5:0]] : PLAIN_MAP[sc[5:0]];
    end
    return ch;
  endfunction

  function automatic logic [7:0] latin_of(input ascii_t ch);
    logic [7:0] lc;
    case (ch)
      7'h61:   lc = 8'hE1;
      7'h41:   lc = 8'hC1;
      7'h65:   lc = 8'hE9;
      7'h45:   lc = 8'hC9;
      7'h69:   lc = 8'hED;
      7'h49:   lc = 8'hCD;
      7'h6F:   lc = 8'hF3;
      7'h4F:   lc = 8'hD3;
      7'h75:   lc = 8'hFA;
      7'h55:   lc = 8'hDA;
      7'h79:   lc = 8'hFC;
      7'h59:   lc = 8'hDC;
      7'h6E:   lc = 8'hF1;
      7'h4E:   lc = 8'hD1;
      7'h63:   lc = 8'hE7;
      7'h43:   lc = 8'hC7;
      7'h31:   lc = 8'hA1;
      7'h21:   lc = 8'hA1;
      7'h3F:   lc = 8'hBF;
      default: lc = {1'b0, ch};
    endcase
    return lc;
  endfunction

endpackage

// File: design/sc1cp_decode.sv
module sc1cp_decode (
  input  logic [7:0]          scan_byte,
  input  sc1cp_pkg::kbd_flags_t flags,
  input  sc1cp_pkg::cfg_codes_t codes,
  output sc1cp_pkg::kbd_flags_t flags_next,
  output sc1cp_pkg::push_req_t  req
);
  import sc1cp_pkg::*;

  logic   ext;
  ascii_t ch;

  assign ext = flags.prefix;

  always_comb begin
    if (scan_byte == SC_DEL) begin
      ch = CH_BS;
    end else if (scan_byte == SC_ENTER) begin
      ch = CH_LF;
    end else begin
      ch = key_char(scan_byte, flags.shift);
    end
  end

  always_comb begin
    flags_next        = flags;
    flags_next.prefix = 1'b0;
    req               = '0;
    if (scan_byte == SC_PREFIX) begin
      flags_next.prefix = 1'b1;
    end else if (scan_byte inside {SC_LSHIFT, SC_RSHIFT}) begin
      flags_next.shift = 1'b1;
    end else if (scan_byte inside {SC_LSHIFT_BRK, SC_RSHIFT_BRK}) begin
      flags_next.shift = 1'b0;
    end else if (scan_byte == SC_ALT) begin
      if (ext) flags_next.altgr = 1'b1;
    end else if (scan_byte == SC_ALT_BRK) begin
      if (ext) flags_next.altgr = 1'b0;
    end else if (ext && (scan_byte inside {SC_LGUI, SC_RGUI})) begin
      flags_next.gui = 1'b1;
    end else if (ext && (scan_byte inside {SC_LGUI_BRK, SC_RGUI_BRK})) begin
      flags_next.gui = 1'b0;
    end else if (!ext && scan_byte == SC_LCTRL) begin
      flags_next.ctrl = 1'b1;
    end else if (!ext && scan_byte == SC_LCTRL_BRK) begin
      flags_next.ctrl = 1'b0;
    end else if (scan_byte[7]) begin
      req.push = 1'b0;
    end else if (ext && scan_byte == SC_UP) begin
      req = '{push: 1'b1, cp: codes.up};
    end else if (ext && scan_byte == SC_DOWN) begin
      req = '{push: 1'b1, cp: codes.down};
    end else if (ext && scan_byte == SC_LEFT) begin
      req = '{push: 1'b1, cp: codes.left};
    end else if (ext && scan_byte == SC_RIGHT) begin
      req = '{push: 1'b1, cp: codes.right};
    end else if (ext && scan_byte == SC_HOME) begin
      req = '{push: 1'b1, cp: codes.home};
    end else if (scan_byte == SC_F1) begin
      req = '{push: 1'b1, cp: codes.fkey_one};
    end else if (ch == CH_NUL) begin
      req.push = 1'b0;
    end else if (ch == CH_SPACE && (flags.gui || flags.ctrl)) begin
      req = '{push: 1'b1, cp: codes.spotlight};
    end else if (flags.altgr) begin
      req = '{push: 1'b1, cp: codepoint_t'(latin_of(ch))};
    end else begin
      req = '{push: 1'b1, cp: codepoint_t'(ch)};
    end
  end

endmodule

// File: design/scancode_set1_to_codepoint_fifo.sv
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_data  : opcode, scan_byte
// out      out_valid / out_ready    out_data : pop_valid, codepoint, ascii_char,
//                                              not_empty, dropped_oldest
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data (cfg_ready is always high)
//
// One word per cycle in, one word per cycle out while out_ready is high; a result passes
// from its input word through the ring read register, then the output register.
// Reset clears the ring indices and the key flags and restores the special-key codes
// to their defaults; the ring contents are left as they are.
// With out_ready low the output register fills, then the read stage, then in_ready drops.
module scancode_set1_to_codepoint_fifo #(
  parameter int RING_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sc1cp_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sc1cp_pkg::out_word_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  sc1cp_pkg::cfg_idx_t   cfg_index,
  input  sc1cp_pkg::codepoint_t cfg_data
);
  import sc1cp_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  codepoint_t ring [RING_DEPTH];
  codepoint_t rd_data;

  logic [IDX_W-1:0] write_index, read_index;
  logic [IDX_W-1:0] write_index_next, read_index_next;
  logic [IDX_W-1:0] w_inc, r_inc;

  cfg_codes_t codes;
  kbd_flags_t flags, flags_next;
  push_req_t  req;

  logic accept, mem_we, mem_re, drop;
  logic s1_valid, s1_pop, s1_not_empty, s1_dropped;
  logic s1_adv;

  out_word_t out_next;

  sc1cp_decode u_decode (
    .scan_byte  (in_data.scan_byte),
    .flags      (flags),
    .codes      (codes),
    .flags_next (flags_next),
    .req        (req)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes <= '{up: RST_UP, down: RST_DOWN, left: RST_LEFT, right: RST_RIGHT,
                 home: RST_HOME, fkey_one: RST_FKEY_ONE, spotlight: RST_SPOTLIGHT};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UP:        codes.up        <= cfg_data;
        CFG_DOWN:      codes.down      <= cfg_data;
        CFG_LEFT:      codes.left      <= cfg_data;
        CFG_RIGHT:     codes.right     <= cfg_data;
        CFG_HOME:      codes.home      <= cfg_data;
        CFG_FKEY_ONE:  codes.fkey_one  <= cfg_data;
        CFG_SPOTLIGHT: codes.spotlight <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  assign w_inc = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
  assign r_inc = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;

  always_comb begin
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    drop             = 1'b0;
    write_index_next = write_index;
    read_index_next  = read_index;
    if (accept) begin
      if (in_data.opcode == OP_SCAN) begin
        if (req.push) begin
          mem_we           = 1'b1;
          write_index_next = w_inc;
          if (w_inc == read_index) begin
            drop            = 1'b1;
            read_index_next = r_inc;
          end
        end
      end else if (write_index != read_index) begin
        mem_re          = 1'b1;
        read_index_next = r_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring[write_index] <= req.cp;
    if (mem_re) rd_data <= ring[read_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      flags       <= '0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      if (accept && in_data.opcode == OP_SCAN) flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop       <= mem_re;
      s1_dropped   <= drop;
      s1_not_empty <= write_index_next != read_index_next;
    end
  end

  always_comb begin
    out_next                = '0;
    out_next.pop_valid      = s1_pop;
    out_next.not_empty      = s1_not_empty;
    out_next.dropped_oldest = s1_dropped;
    if (s1_pop) begin
      out_next.codepoint  = rd_data;
      out_next.ascii_char = (rd_data <= ASCII_MAX) ? rd_data[ASCII_W-1:0] : CH_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_data <= out_next;
  end

`ifndef SYNTHESIS
  a_pop_or_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.pop_valid && out_data.dropped_oldest))
    else $error("pop and drop reported in one word");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.pop_valid) |->
      (out_data.codepoint == '0 && out_data.ascii_char == '0))
    else $error("non-pop word carries a codepoint");

  a_drop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dropped_oldest) |-> out_data.not_empty)
    else $error("drop reported with an empty ring");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with the output register empty");
`endif

endmodule

// File: tb/tb_scancode_set1_to_codepoint_fifo.sv
`timescale 1ns / 100ps

module tb_scancode_set1_to_codepoint_fifo;
  import sc1cp_pkg::*;

  localparam int RING_SLOTS   = 128;
  localparam int KEY_ROWS     = 58;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 200000;

  localparam logic [7:0] SC_NONE  = 8'h00;
  localparam logic [7:0] SC_ESC   = 8'h01;
  localparam logic [7:0] SC_ONE   = 8'h02;
  localparam logic [7:0] SC_TAB   = 8'h0F;
  localparam logic [7:0] SC_A     = 8'h1E;
  localparam logic [7:0] SC_SLASH = 8'h35;
  localparam logic [7:0] SC_SPACE = 8'h39;
  localparam logic [7:0] SC_CAPS  = 8'h3A;
  localparam logic [7:0] SC_BREAK = 8'h80;

  localparam ascii_t CH_ESC = 7'h1B;
  localparam ascii_t CH_TAB = 7'h09;

  localparam logic [7:0] SHIFT_KEYS [4] = '{SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_BRK, SC_RSHIFT_BRK};
  localparam logic [7:0] GUI_KEYS [4]   = '{SC_LGUI, SC_RGUI, SC_LGUI_BRK, SC_RGUI_BRK};
  localparam logic [7:0] NAV_KEYS [5]   = '{SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME};
  localparam logic [7:0] MISC_KEYS [3]  = '{SC_F1, SC_DEL, SC_ENTER};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = CFG_UP;
  codepoint_t cfg_data = '0;

  scancode_set1_to_codepoint_fifo uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // keyboard and ring state as the block should hold it
  codepoint_t                      key_codes [CFG_UP:CFG_SPOTLIGHT];
  codepoint_t                      ring_copy [RING_SLOTS];
  logic [$clog2(RING_SLOTS)-1:0]   wr_ptr = '0;
  logic [$clog2(RING_SLOTS)-1:0]   rd_ptr = '0;
  logic shift_on = 1'b0;
  logic altgr_on = 1'b0;
  logic e0_pending = 1'b0;
  logic gui_on = 1'b0;
  logic ctrl_on = 1'b0;

  in_word_t  pending_words [$];
  out_word_t expected_results [$];
  int  words_issued = 0;
  int  words_accepted = 0;
  int  results_seen = 0;
  int  codes_popped = 0;
  int  oldest_dropped = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  holds_asked = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  logic calm = 1'b0;
  logic in_fire = 1'b0;

  initial begin
    key_codes[CFG_UP]        = RST_UP;
    key_codes[CFG_DOWN]      = RST_DOWN;
    key_codes[CFG_LEFT]      = RST_LEFT;
    key_codes[CFG_RIGHT]     = RST_RIGHT;
    key_codes[CFG_HOME]      = RST_HOME;
    key_codes[CFG_FKEY_ONE]  = RST_FKEY_ONE;
    key_codes[CFG_SPOTLIGHT] = RST_SPOTLIGHT;
  end

  function automatic ascii_t table_char(logic [7:0] sc, logic shifted);
    string  row;
    ascii_t ch;
    if (shifted) begin
      row = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>? *  ";
    end else begin
      row = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./ *  ";
    end
    case (sc)
      SC_NONE, SC_LCTRL, SC_LSHIFT, SC_RSHIFT, SC_ALT: ch = CH_NUL;
      SC_ESC:   ch = CH_ESC;
      SC_BKSP:  ch = CH_BS;
      SC_TAB:   ch = CH_TAB;
      SC_ENTER: ch = CH_LF;
      default:  ch = ascii_t'(row[int'(sc)]);
    endcase
    return ch;
  endfunction

  function automatic codepoint_t accent_of(ascii_t ch);
    logic [7:0] acc;
    case ({1'b0, ch})
      "a": acc = 8'hE1;
      "A": acc = 8'hC1;
      "e": acc = 8'hE9;
      "E": acc = 8'hC9;
      "i": acc = 8'hED;
      "I": acc = 8'hCD;
      "o": acc = 8'hF3;
      "O": acc = 8'hD3;
      "u": acc = 8'hFA;
      "U": acc = 8'hDA;
      "y": acc = 8'hFC;
      "Y": acc = 8'hDC;
      "n": acc = 8'hF1;
      "N": acc = 8'hD1;
      "c": acc = 8'hE7;
      "C": acc = 8'hC7;
      "1", "!": acc = 8'hA1;
      "?": acc = 8'hBF;
      default: acc = {1'b0, ch};
    endcase
    return codepoint_t'(acc);
  endfunction

  function automatic logic push_code(codepoint_t cp);
    logic [$clog2(RING_SLOTS)-1:0] nxt;
    logic lost;
    nxt = wr_ptr + 1'b1;
    lost = (nxt == rd_ptr);
    if (lost) rd_ptr = rd_ptr + 1'b1;
    ring_copy[wr_ptr] = cp;
    wr_ptr = nxt;
    return lost;
  endfunction

  function automatic logic decode_scan(logic [7:0] sc);
    logic   ext;
    ascii_t ch;
    if (sc == SC_PREFIX) begin
      e0_pending = 1'b1;
      return 1'b0;
    end
    ext = e0_pending;
    e0_pending = 1'b0;
    if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
      shift_on = 1'b1;
      return 1'b0;
    end
    if (sc == SC_LSHIFT_BRK || sc == SC_RSHIFT_BRK) begin
      shift_on = 1'b0;
      return 1'b0;
    end
    if (sc == SC_ALT) begin
      if (ext) altgr_on = 1'b1;
      return 1'b0;
    end
    if (sc == SC_ALT_BRK) begin
      if (ext) altgr_on = 1'b0;
      return 1'b0;
    end
    if (ext && (sc == SC_LGUI || sc == SC_RGUI)) begin
      gui_on = 1'b1;
      return 1'b0;
    end
    if (ext && (sc == SC_LGUI_BRK || sc == SC_RGUI_BRK)) begin
      gui_on = 1'b0;
      return 1'b0;
    end
    if (!ext && sc == SC_LCTRL) begin
      ctrl_on = 1'b1;
      return 1'b0;
    end
    if (!ext && sc == SC_LCTRL_BRK) begin
      ctrl_on = 1'b0;
      return 1'b0;
    end
    if (sc[7]) return 1'b0;
    if (ext) begin
      case (sc)
        SC_UP:    return push_code(key_codes[CFG_UP]);
        SC_DOWN:  return push_code(key_codes[CFG_DOWN]);
        SC_LEFT:  return push_code(key_codes[CFG_LEFT]);
        SC_RIGHT: return push_code(key_codes[CFG_RIGHT]);
        SC_HOME:  return push_code(key_codes[CFG_HOME]);
        default: ;
      endcase
    end
    if (sc == SC_F1) return push_code(key_codes[CFG_FKEY_ONE]);
    if (sc == SC_ENTER) ch = CH_LF;
    else if (sc == SC_BKSP || sc == SC_DEL) ch = CH_BS;
    else if (sc < KEY_ROWS) ch = table_char(sc, shift_on);
    else ch = CH_NUL;
    if (ch == CH_NUL) return 1'b0;
    if (ch == CH_SPACE && (gui_on || ctrl_on)) return push_code(key_codes[CFG_SPOTLIGHT]);
    return push_code(altgr_on ? accent_of(ch) : codepoint_t'(ch));
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.opcode == OP_POP) begin
      if (wr_ptr != rd_ptr) begin
        r.pop_valid  = 1'b1;
        r.codepoint  = ring_copy[rd_ptr];
        r.ascii_char = (r.codepoint <= ASCII_MAX) ? r.codepoint[6:0] : CH_UNKNOWN;
        rd_ptr = rd_ptr + 1'b1;
      end
    end else begin
      r.dropped_oldest = decode_scan(w.scan_byte);
    end
    r.not_empty = (wr_ptr != rd_ptr);
    return r;
  endfunction

  // check the output word, then predict the input word taken at this edge
  always @(posedge clk) begin
    out_word_t want;
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("cycle %0d: result %h with nothing expected", cycles, out_data);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        codes_popped += want.pop_valid;
        oldest_dropped += want.dropped_oldest;
        if (out_data.pop_valid !== want.pop_valid || out_data.codepoint !== want.codepoint ||
            out_data.ascii_char !== want.ascii_char || out_data.not_empty !== want.not_empty ||
            out_data.dropped_oldest !== want.dropped_oldest) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cycle %0d: expected valid=%b cp=%h ascii=%h ne=%b drop=%b", cycles,
                     want.pop_valid, want.codepoint, want.ascii_char, want.not_empty,
                     want.dropped_oldest);
            $display("          actual   valid=%b cp=%h ascii=%h ne=%b drop=%b",
                     out_data.pop_valid, out_data.codepoint, out_data.ascii_char,
                     out_data.not_empty, out_data.dropped_oldest);
          end
        end
      end
    end
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      expected_results.push_back(predict_word(in_data));
      words_accepted++;
    end
  end

  // hold the word until taken, then advance or idle
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_scan(logic [7:0] sc);
    in_word_t w;
    w.opcode    = OP_SCAN;
    w.scan_byte = sc;
    pending_words.push_back(w);
    words_issued++;
  endtask

  task automatic send_pop();
    in_word_t w;
    w.opcode    = OP_POP;
    w.scan_byte = 8'($urandom_range(255));
    pending_words.push_back(w);
    words_issued++;
  endtask

  task automatic wait_drained();
    while (words_accepted != words_issued || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_code(cfg_idx_t idx, codepoint_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    key_codes[idx] = val;
  endtask

  task automatic set_codes(int phase);
    codepoint_t v;
    for (int i = CFG_UP; i <= CFG_SPOTLIGHT; i++) begin
      if (phase == 1) v = '0;
      else if (phase == 2) v = '1;
      else if ($urandom_range(1)) v = codepoint_t'($urandom_range(127));
      else v = codepoint_t'($urandom_range(21'h1FFFFF));
      write_code(cfg_idx_t'(i), v);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_phase(int n, int pop_pct);
    int target;
    int r;
    logic [7:0] k;
    target = words_issued + n;
    while (words_issued < target) begin
      r = $urandom_range(99);
      if (r < pop_pct) begin
        send_pop();
      end else if (r < pop_pct + 8) begin
        k = 8'($urandom_range(255));
        send_scan(k);
      end else begin
        case ($urandom_range(9))
          0: send_scan(SHIFT_KEYS[2'($urandom_range(3))]);
          1: begin
            send_scan(SC_PREFIX);
            send_scan($urandom_range(1) ? SC_ALT : SC_ALT_BRK);
          end
          2: begin
            send_scan(SC_PREFIX);
            send_scan(GUI_KEYS[2'($urandom_range(3))]);
          end
          3: send_scan($urandom_range(1) ? SC_LCTRL : SC_LCTRL_BRK);
          4: begin
            if ($urandom_range(3) != 0) send_scan(SC_PREFIX);
            send_scan(NAV_KEYS[3'($urandom_range(4))]);
          end
          5: begin
            if ($urandom_range(3) == 0) send_scan(SC_PREFIX);
            send_scan(MISC_KEYS[2'($urandom_range(2))]);
          end
          6: send_scan(SC_SPACE);
          default: begin
            k = 8'($urandom_range(KEY_ROWS - 1));
            send_scan(k);
            if ($urandom_range(1)) send_scan(k | SC_BREAK);
          end
        endcase
      end
    end
  endtask

  initial begin
    int pop_rates [6];
    pop_rates = '{35, 10, 50, 5, 40, 30};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_pop();
    send_scan(SC_NONE);
    send_scan(8'hFF);
    send_scan(SC_LSHIFT);
    send_scan(SC_A);
    send_scan(SC_RSHIFT_BRK);
    send_scan(SC_PREFIX);
    send_scan(SC_ALT);
    send_scan(SC_ONE);
    send_scan(SC_LSHIFT);
    send_scan(SC_SLASH);
    send_scan(SC_LSHIFT_BRK);
    send_scan(SC_PREFIX);
    send_scan(SC_ALT_BRK);
    send_scan(SC_ALT);
    send_scan(SC_PREFIX);
    send_scan(SC_UP);
    send_scan(SC_PREFIX);
    send_scan(SC_F1);
    send_scan(SC_DEL);
    send_scan(SC_LCTRL);
    send_scan(SC_SPACE);
    send_scan(SC_LCTRL_BRK);
    send_scan(SC_CAPS);
    send_scan(SC_ENTER);
    repeat (9) send_pop();
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p != 0) set_codes(p);
      calm = (p == 3);
      if (p == 2) holds_asked++;
      queue_phase(250, pop_rates[p]);
      wait_drained();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    $display("%0d words driven, %0d results checked: %0d codes popped, %0d oldest entries dropped",
             words_accepted, results_seen, codes_popped, oldest_dropped);
    $display("special-key codes at reset, all zero, all one and random; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
